FILE: design/timed_touch_pattern_lock_top_assert.svh
// Assertion helpers for the touch pattern lock. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef TIMED_TOUCH_PATTERN_LOCK_TOP_ASSERT_SVH
`define TIMED_TOUCH_PATTERN_LOCK_TOP_ASSERT_SVH

`define TTPL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttpl: same-cycle check failed");

`define TTPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttpl: next-cycle check failed");

`endif

FILE: design/ttpl_pkg.sv
package ttpl_pkg;

  localparam int LOG_DEPTH_DEF     = 32;
  localparam int PATTERN_STEPS_DEF = 4;

  localparam int LEVEL_W = 2;
  localparam int DUR_W   = 16;
  localparam int ENTRY_W = LEVEL_W + DUR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0]       EMPTY_LEVEL = 3'd4;
  localparam logic [DUR_W-1:0] DUR_MAX     = 16'hffff;

  localparam logic [7:0]  PAT_LEVELS_RST = 8'd36;
  localparam logic [31:0] PAT_MIN_RST    = 32'h0505_0505;
  localparam logic [31:0] PAT_MAX_RST    = 32'hc8c8_c8c8;
  localparam logic [15:0] BLIP_RST       = 16'd20;
  localparam logic [7:0]  TRIGGER_RST    = 8'd2;
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
  localparam logic [15:0] OUT_TIME_RST   = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEVELS = 3'd0,
    REG_PAT_MIN    = 3'd1,
    REG_PAT_MAX    = 3'd2,
    REG_BLIP       = 3'd3,
    REG_TRIGGER    = 3'd4,
    REG_TIMEOUT    = 3'd5,
    REG_OUT_TIME   = 3'd6
  } ttpl_reg_e;

  typedef struct packed {
    logic start;
    logic walk;
    logic evt;
    logic log_run;
    logic emit;
  } ttpl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } ttpl_sts_t;

endpackage

FILE: design/ttpl_ram.sv
module ttpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/ttpl_ctrl.sv
module ttpl_ctrl import ttpl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ttpl_sts_t sts_i,
  output ttpl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EVENT,
    S_LOG,
    S_EMIT
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.start   = in_valid_i;
      S_WALK:  cmd_o.walk    = !sts_i.walk_done;
      S_EVENT: cmd_o.evt     = 1'b1;
      S_LOG:   cmd_o.log_run = 1'b1;
      S_EMIT:  cmd_o.emit    = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_WALK;
        S_WALK:  if (sts_i.walk_done) state_q <= S_EVENT;
        S_EVENT: state_q <= S_LOG;
        S_LOG:   state_q <= S_EMIT;
        S_EMIT:  if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/ttpl_dp.sv
module ttpl_dp import ttpl_pkg::*; #(
  parameter int LOG_DEPTH     = LOG_DEPTH_DEF,
  parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ttpl_cmd_t             cmd_i,
  output ttpl_sts_t             sts_o,
  input  logic [LEVEL_W-1:0]    sensor_level_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  actuator_on_o,
  output logic                  pattern_seen_o,
  output logic                  fired_o,
  output logic [7:0]            matches_counted_o
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int SW = (PATTERN_STEPS > 1) ? $clog2(PATTERN_STEPS) : 1;

  // Configuration registers.
  logic [7:0]  pat_levels_q;
  logic [31:0] pat_min_q, pat_max_q;
  logic [15:0] blip_q, timeout_q, out_time_q;
  logic [7:0]  trigger_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_levels_q <= PAT_LEVELS_RST;
      pat_min_q    <= PAT_MIN_RST;
      pat_max_q    <= PAT_MAX_RST;
      blip_q       <= BLIP_RST;
      trigger_q    <= TRIGGER_RST;
      timeout_q    <= TIMEOUT_RST;
      out_time_q   <= OUT_TIME_RST;
    end else if (cfg_valid_i) begin
      case (ttpl_reg_e'(cfg_index_i))
        REG_PAT_LEVELS: pat_levels_q <= cfg_data_i[7:0];
        REG_PAT_MIN:    pat_min_q    <= cfg_data_i;
        REG_PAT_MAX:    pat_max_q    <= cfg_data_i;
        REG_BLIP:       blip_q       <= cfg_data_i[15:0];
        REG_TRIGGER:    trigger_q    <= cfg_data_i[7:0];
        REG_TIMEOUT:    timeout_q    <= cfg_data_i[15:0];
        REG_OUT_TIME:   out_time_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Run log: the RAM holds written entries; per-entry flags tell apart a
  // written entry, one cleared by a match (0/0) and one untouched since reset.
  logic [LOG_DEPTH-1:0] tag_valid_q, tag_zero_q;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

  logic [AW-1:0]        newest_q;
  logic [2:0]           newest_lvl_q;
  logic [DUR_W-1:0]     newest_dur_q;
  logic [LEVEL_W-1:0]   sample_q;

  // Walk state.
  logic [AW-1:0]        rd_slot_q;
  logic [CW-1:0]        issued_q;
  logic                 rd_pend_q, rd_valid_q, rd_zero_q;
  logic                 stop_q, seen_q, fired_q;
  logic [SW-1:0]        step_q;

  // Event and output timers.
  logic [7:0]           count_q;
  logic [15:0]          evt_cnt_q, out_cnt_q;
  logic                 drive_q;

  ttpl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LOG_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_slot_q),
    .rdata_o(ram_rdata)
  );

  logic [2:0]       ent_lvl;
  logic [DUR_W-1:0] ent_dur;
  logic [1:0]       step_sel;
  logic [1:0]       pat_lvl;
  logic [7:0]       pat_lo, pat_hi;
  logic             fits, last_step, issue;

  always_comb begin
    if (rd_valid_q) begin
      ent_lvl = {1'b0, ram_rdata[DUR_W +: LEVEL_W]};
      ent_dur = ram_rdata[DUR_W-1:0];
    end else if (rd_zero_q) begin
      ent_lvl = '0;
      ent_dur = '0;
    end else begin
      ent_lvl = EMPTY_LEVEL;
      ent_dur = DUR_MAX;
    end
  end

  assign step_sel  = 2'(step_q);
  assign pat_lvl   = pat_levels_q[{step_sel, 1'b0} +: 2];
  assign pat_lo    = pat_min_q[{step_sel, 3'b000} +: 8];
  assign pat_hi    = pat_max_q[{step_sel, 3'b000} +: 8];
  assign fits      = (ent_lvl == {1'b0, pat_lvl}) && (ent_dur >= {8'd0, pat_lo}) &&
                     (ent_dur <= {8'd0, pat_hi});
  assign last_step = (step_q == SW'(PATTERN_STEPS - 1));
  assign issue     = (issued_q < CW'(LOG_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q  <= '0;
      issued_q   <= '0;
      rd_pend_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_zero_q  <= 1'b0;
      stop_q     <= 1'b0;
      seen_q     <= 1'b0;
      step_q     <= '0;
      sample_q   <= '0;
    end else if (cmd_i.start) begin
      rd_slot_q <= newest_q;
      issued_q  <= '0;
      rd_pend_q <= 1'b0;
      stop_q    <= 1'b0;
      seen_q    <= 1'b0;
      step_q    <= '0;
      sample_q  <= sensor_level_i;
    end else if (cmd_i.walk) begin
      // One read goes out while the previous one is compared.
      if (issue) begin
        rd_slot_q  <= (rd_slot_q == '0) ? AW'(LOG_DEPTH - 1) : rd_slot_q - 1'b1;
        issued_q   <= issued_q + 1'b1;
        rd_valid_q <= tag_valid_q[rd_slot_q];
        rd_zero_q  <= tag_zero_q[rd_slot_q];
      end
      rd_pend_q <= issue;
      // The walk ends after the last entry, on a full match, or on a long miss.
      stop_q    <= !issue || (rd_pend_q && (fits ? last_step : (ent_dur > blip_q)));
      if (rd_pend_q && fits) begin
        if (last_step) begin
          seen_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.walk_done = stop_q;

  // Logging of the new sample.
  logic             chg;
  logic [AW-1:0]    slot_nxt, wslot;
  logic [DUR_W-1:0] wdur;

  assign chg      = ({1'b0, sample_q} != newest_lvl_q);
  assign slot_nxt = (newest_q == AW'(LOG_DEPTH - 1)) ? '0 : newest_q + 1'b1;
  assign wslot    = chg ? slot_nxt : newest_q;
  always_comb begin
    if (chg) begin
      wdur = DUR_W'(1);
    end else if (newest_dur_q != DUR_MAX) begin
      wdur = newest_dur_q + 1'b1;
    end else begin
      wdur = newest_dur_q;
    end
  end

  assign ram_we    = cmd_i.log_run;
  assign ram_waddr = wslot;
  assign ram_wdata = {sample_q, wdur};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_valid_q  <= '0;
      tag_zero_q   <= '0;
      newest_q     <= '0;
      newest_lvl_q <= EMPTY_LEVEL;
      newest_dur_q <= DUR_MAX;
    end else if (cmd_i.evt && seen_q) begin
      tag_valid_q  <= '0;
      tag_zero_q   <= '1;
      newest_lvl_q <= '0;
      newest_dur_q <= '0;
    end else if (cmd_i.log_run) begin
      tag_valid_q[wslot] <= 1'b1;
      newest_q           <= wslot;
      newest_lvl_q       <= {1'b0, sample_q};
      newest_dur_q       <= wdur;
    end
  end

  logic [7:0] cnt_inc;
  assign cnt_inc = count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      evt_cnt_q <= '0;
      out_cnt_q <= '0;
      drive_q   <= 1'b0;
      fired_q   <= 1'b0;
    end else if (cmd_i.start) begin
      fired_q <= 1'b0;
    end else if (cmd_i.evt) begin
      if (seen_q) begin
        if (cnt_inc >= trigger_q) begin
          fired_q   <= 1'b1;
          count_q   <= '0;
          evt_cnt_q <= '0;
          drive_q   <= 1'b1;
          out_cnt_q <= out_time_q;
        end else begin
          count_q   <= cnt_inc;
          evt_cnt_q <= timeout_q;
        end
      end
    end else if (cmd_i.log_run) begin
      if (evt_cnt_q != '0) begin
        evt_cnt_q <= evt_cnt_q - 1'b1;
      end else begin
        count_q <= '0;
      end
      if (out_cnt_q != '0) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end else begin
        drive_q <= 1'b0;
      end
    end
  end

  // Output register: the next request may be taken while a result waits.
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      actuator_on_o     <= drive_q;
      pattern_seen_o    <= seen_q;
      fired_o           <= fired_q;
      matches_counted_o <= count_q;
    end
  end

endmodule

FILE: design/timed_touch_pattern_lock_top.sv
// Each request walks backward over the run log, stopping early on a full match or
// a long miss; the walk reads one entry a cycle. The states run IDLE, WALK, EVENT,
// LOG, EMIT, and a new request is taken only once the last is back in IDLE.
// Reset is asynchronous and active low; the log reads as empty right after reset
// through per-entry flags, so there is no clearing pass.
`include "timed_touch_pattern_lock_top_assert.svh"

module timed_touch_pattern_lock_top import ttpl_pkg::*; #(
  parameter int LOG_DEPTH     = LOG_DEPTH_DEF,
  parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [LEVEL_W-1:0]    sensor_level_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  actuator_on_o,
  output logic                  pattern_seen_o,
  output logic                  fired_o,
  output logic [7:0]            matches_counted_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ttpl_cmd_t  cmd;
  ttpl_sts_t  sts;
  logic [4:0] cmd_bits;

  assign cfg_ready_o = 1'b1;
  assign cmd_bits    = cmd;

  ttpl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ttpl_dp #(
    .LOG_DEPTH    (LOG_DEPTH),
    .PATTERN_STEPS(PATTERN_STEPS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sensor_level_i   (sensor_level_i),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .actuator_on_o    (actuator_on_o),
    .pattern_seen_o   (pattern_seen_o),
    .fired_o          (fired_o),
    .matches_counted_o(matches_counted_o)
  );

  // Firing always comes from a match and leaves the count at zero.
  `TTPL_ASSERT_IMPLIES(a_fire_clears, out_valid_o && fired_o,
                       pattern_seen_o && (matches_counted_o == 8'd0))
  `TTPL_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)
  `TTPL_ASSERT_IMPLIES(a_cmd_exclusive, 1'b1, $onehot0(cmd_bits))
  `TTPL_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_o)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ttpl_pkg::*;

  localparam int RUN_SLOTS    = LOG_DEPTH_DEF;
  localparam int STEPS        = PATTERN_STEPS_DEF;
  localparam int RANDOM_TICKS = 2000;
  localparam int IDLE_LIMIT   = 2000;
  localparam int REPORT_LIMIT = 40;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic       actuator_on;
    logic       pattern_seen;
    logic       fired;
    logic [7:0] matches_counted;
  } lock_result_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BLOCK} stall_mode_e;

  class lock_tracker;
    logic [7:0]  levels_cfg;
    logic [31:0] min_cfg;
    logic [31:0] max_cfg;
    logic [15:0] blip_cfg;
    logic [7:0]  trigger_cfg;
    logic [15:0] timeout_cfg;
    logic [15:0] out_time_cfg;
    logic [2:0]  run_level [RUN_SLOTS];
    logic [15:0] run_len [RUN_SLOTS];
    int unsigned newest;
    logic [7:0]  count;
    logic [15:0] event_left;
    logic [15:0] drive_left;
    logic        drive;
    lock_result_t due_outputs[$];
    int          errors;

    function new();
      levels_cfg   = PAT_LEVELS_RST;
      min_cfg      = PAT_MIN_RST;
      max_cfg      = PAT_MAX_RST;
      blip_cfg     = BLIP_RST;
      trigger_cfg  = TRIGGER_RST;
      timeout_cfg  = TIMEOUT_RST;
      out_time_cfg = OUT_TIME_RST;
      for (int i = 0; i < RUN_SLOTS; i++) begin
        run_level[i] = EMPTY_LEVEL;
        run_len[i]   = DUR_MAX;
      end
      newest     = 0;
      count      = '0;
      event_left = '0;
      drive_left = '0;
      drive      = 1'b0;
      errors     = 0;
    endfunction

    // Bits above a register's width are dropped; unknown indexes are ignored.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PAT_LEVELS: levels_cfg   = data[7:0];
        REG_PAT_MIN:    min_cfg      = data;
        REG_PAT_MAX:    max_cfg      = data;
        REG_BLIP:       blip_cfg     = data[15:0];
        REG_TRIGGER:    trigger_cfg  = data[7:0];
        REG_TIMEOUT:    timeout_cfg  = data[15:0];
        REG_OUT_TIME:   out_time_cfg = data[15:0];
        default: ;
      endcase
    endfunction

    function bit run_fits(int unsigned slot, int unsigned k);
      return run_level[slot] == {1'b0, levels_cfg[2*k +: 2]} &&
             run_len[slot] >= {8'd0, min_cfg[8*k +: 8]} &&
             run_len[slot] <= {8'd0, max_cfg[8*k +: 8]};
    endfunction

    function void note_tick(logic [1:0] sample);
      int unsigned k;
      int unsigned slot;
      lock_result_t res;
      k = 0;
      res = '0;
      // Walk from the newest run back; short unmatched runs count as blips.
      for (int i = 0; i < RUN_SLOTS; i++) begin
        slot = (newest + RUN_SLOTS - i) % RUN_SLOTS;
        if (run_fits(slot, k)) begin
          k++;
          if (k < STEPS) continue;
          res.pattern_seen = 1'b1;
          for (int j = 0; j < RUN_SLOTS; j++) begin
            run_level[j] = 3'd0;
            run_len[j]   = 16'd0;
          end
          count = count + 8'd1;
          event_left = timeout_cfg;
          if (count >= trigger_cfg) begin
            res.fired  = 1'b1;
            count      = '0;
            event_left = '0;
            drive      = 1'b1;
            drive_left = out_time_cfg;
          end
          break;
        end
        if (run_len[slot] > blip_cfg) break;
      end
      if (event_left != 16'd0) event_left = event_left - 16'd1;
      else count = '0;
      if (drive_left != 16'd0) drive_left = drive_left - 16'd1;
      else drive = 1'b0;
      if ({1'b0, sample} != run_level[newest]) begin
        newest = (newest + 1) % RUN_SLOTS;
        run_level[newest] = {1'b0, sample};
        run_len[newest]   = 16'd1;
      end else if (run_len[newest] != DUR_MAX) begin
        run_len[newest] = run_len[newest] + 16'd1;
      end
      res.actuator_on     = drive;
      res.matches_counted = count;
      due_outputs.push_back(res);
    endfunction

    function void field_ok(string name, int want, int got);
      if (want != got) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_output(lock_result_t got);
      lock_result_t want;
      if (due_outputs.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, got);
        errors++;
        return;
      end
      want = due_outputs.pop_front();
      field_ok("actuator_on", want.actuator_on, got.actuator_on);
      field_ok("pattern_seen", want.pattern_seen, got.pattern_seen);
      field_ok("fired", want.fired, got.fired);
      field_ok("matches_counted", want.matches_counted, got.matches_counted);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [LEVEL_W-1:0]    sensor_level_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  actuator_on_o;
  logic                  pattern_seen_o;
  logic                  fired_o;
  logic [7:0]            matches_counted_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lock_tracker tracker;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          ticks_sent = 0;
  logic [1:0]  last_level = 2'd0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_hold = 0;

  timed_touch_pattern_lock_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sensor_level_i    (sensor_level_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .actuator_on_o     (actuator_on_o),
    .pattern_seen_o    (pattern_seen_o),
    .fired_o           (fired_o),
    .matches_counted_o (matches_counted_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_tick(sensor_level_i);
      if (out_valid_o && !out_stall_i)
        tracker.check_output({actuator_on_o, pattern_seen_o, fired_o, matches_counted_o});
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_data_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // The result side switches at random between stall patterns.
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_hold = $urandom_range(20, 250);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= (stall_hold % 64) < 40;
    endcase
  end

  task automatic send_tick(input logic [1:0] lvl);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    sensor_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_level = lvl;
    ticks_sent++;
  endtask

  task automatic send_run(input logic [1:0] lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Every tick yields a result, so an empty queue means the block is idle.
  // The first edge lets the monitor note a request taken at the current one.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.due_outputs.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Narrow registers get random junk in the unused upper data bits.
  task automatic apply_setup(input logic [7:0] levels, input logic [31:0] mins,
                             input logic [31:0] maxs, input logic [15:0] blip,
                             input logic [7:0] trig, input logic [15:0] tout,
                             input logic [15:0] otime);
    logic [31:0] junk;
    settle();
    junk = $urandom();
    junk[7:0] = levels;
    write_reg(REG_PAT_LEVELS, junk);
    write_reg(REG_PAT_MIN, mins);
    write_reg(REG_PAT_MAX, maxs);
    junk = $urandom();
    junk[15:0] = blip;
    write_reg(REG_BLIP, junk);
    junk = $urandom();
    junk[7:0] = trig;
    write_reg(REG_TRIGGER, junk);
    junk = $urandom();
    junk[15:0] = tout;
    write_reg(REG_TIMEOUT, junk);
    junk = $urandom();
    junk[15:0] = otime;
    write_reg(REG_OUT_TIME, junk);
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom());
  endtask

  function automatic logic [15:0] pick_span();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 100));
      2: return 16'hffff;
      default: return 16'($urandom_range(100, 2000));
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] mins;
    logic [31:0] maxs;
    logic [15:0] blip;
    logic [7:0]  trig;
    for (int b = 0; b < STEPS; b++) begin
      mins[8*b +: 8] = 8'($urandom_range(0, 4));
      maxs[8*b +: 8] = ($urandom_range(0, 7) == 0) ? 8'hff
                       : mins[8*b +: 8] + 8'($urandom_range(0, 5));
      if ($urandom_range(0, 15) == 0) maxs[8*b +: 8] = 8'd0;
    end
    case ($urandom_range(0, 3))
      0: blip = 16'd0;
      1: blip = 16'($urandom_range(1, 4));
      2: blip = 16'($urandom_range(5, 40));
      default: blip = 16'($urandom());
    endcase
    trig = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 3));
    apply_setup(8'($urandom()), mins, maxs, blip, trig, pick_span(), pick_span());
  endtask

  // Runs for each pattern step, oldest first, with optional blips between them
  // and now and then a duration just outside the window.
  task automatic play_pattern();
    logic [1:0] lvl;
    logic [1:0] other;
    int lo;
    int hi;
    int len;
    for (int k = STEPS - 1; k >= 0; k--) begin
      lvl = tracker.levels_cfg[2*k +: 2];
      lo  = tracker.min_cfg[8*k +: 8];
      hi  = tracker.max_cfg[8*k +: 8];
      if (tracker.blip_cfg != 16'd0 && (lvl == last_level || $urandom_range(0, 3) == 0)) begin
        other = 2'($urandom_range(0, 3));
        while (other == lvl || other == last_level) other = other + 2'd1;
        send_run(other, $urandom_range(1, tracker.blip_cfg < 16'd3 ? tracker.blip_cfg : 3));
      end
      len = (lo <= hi) ? lo + $urandom_range(0, (hi - lo) < 4 ? hi - lo : 4) : lo;
      case ($urandom_range(0, 9))
        0: len = hi + 1;
        1: len = lo - 1;
        default: ;
      endcase
      if (len < 1) len = 1;
      send_run(lvl, len);
    end
    send_tick(2'($urandom_range(0, 3)));
  endtask

  task automatic play_noise();
    repeat ($urandom_range(1, 6))
      send_run(2'($urandom_range(0, 3)),
               $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4));
  endtask

  task automatic run_mix(input int n);
    int stop_at;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) play_pattern();
      else play_noise();
    end
  endtask

  initial begin
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: every level once, then the default pattern at its
    // shortest durations.
    send_tick(2'd3);
    send_tick(2'd0);
    send_tick(2'd1);
    send_tick(2'd2);
    send_run(2'd0, 5);
    send_run(2'd2, 5);
    send_run(2'd1, 5);
    send_run(2'd0, 5);
    send_tick(2'd3);

    // Widest windows, zero timeout and zero output time.
    apply_setup(8'h00, 32'h0000_0000, 32'hffff_ffff, 16'hffff, 8'd1, 16'd0, 16'd0);
    run_mix(60);
    // Trigger of zero fires on the first match; longest timers.
    apply_setup(8'hff, 32'h0101_0101, 32'h0303_0303, 16'd2, 8'd0, 16'hffff, 16'hffff);
    run_mix(60);
    // Build up a count, then lower the trigger beneath it.
    apply_setup(8'($urandom()), 32'h0101_0101, 32'h0404_0404, 16'd3, 8'd3,
                16'hffff, 16'd20);
    repeat (2) play_pattern();
    settle();
    write_reg(REG_NONE, $urandom());
    write_reg(REG_TRIGGER, {24'($urandom()), 8'd1});
    run_mix(40);

    while (ticks_sent < RANDOM_TICKS) begin
      random_setup();
      run_mix($urandom_range(60, 200));
    end

    settle();
    repeat (RUN_SLOTS + 10) @(posedge clk_i);
    if (tracker.due_outputs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.due_outputs.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: timed_touch_pattern_lock_top.f
+incdir+design
design/ttpl_pkg.sv
design/ttpl_ram.sv
design/ttpl_ctrl.sv
design/ttpl_dp.sv
design/timed_touch_pattern_lock_top.sv
tb/tb_top.sv
